// ----- design/car_pkg.sv -----
`default_nettype none
package car_pkg;

    localparam int SAMPLE_RATE  = 48000;
    localparam int PREDELAY_MAX = 4096;

    localparam int C1_LEN = SAMPLE_RATE * 297 / 10000;
    localparam int C2_LEN = SAMPLE_RATE * 371 / 10000;
    localparam int D1_LEN = SAMPLE_RATE * 5 / 1000;
    localparam int D2_LEN = SAMPLE_RATE * 17 / 10000;

    localparam int C1_BASE    = 0;
    localparam int C2_BASE    = C1_BASE + C1_LEN;
    localparam int D1_BASE    = C2_BASE + C2_LEN;
    localparam int D2_BASE    = D1_BASE + D1_LEN;
    localparam int MAIN_DEPTH = D2_BASE + D2_LEN;

    localparam int MAIN_AW = $clog2(MAIN_DEPTH);
    localparam int PD_AW   = $clog2(PREDELAY_MAX);
    localparam int C1_PW   = $clog2(C1_LEN);
    localparam int C2_PW   = $clog2(C2_LEN);
    localparam int D1_PW   = $clog2(D1_LEN);
    localparam int D2_PW   = $clog2(D2_LEN);

    localparam int SAMPLE_W   = 16;
    localparam int STORE_W    = 24;
    localparam int PLEN_W     = 13;
    localparam int DECAY_W    = 15;
    localparam int DAMP_W     = 15;
    localparam int WET_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    localparam int DECAY_LO    = 1638;
    localparam int DECAY_HI    = 31130;
    localparam int DAMP_HI     = 29491;
    localparam int UNITY       = 32768;
    localparam int PLEN_RESET  = 960;
    localparam int DECAY_RESET = 16384;
    localparam int DAMP_RESET  = 8192;
    localparam int WET_RESET   = 16384;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PLEN  = 2'd0,
        REG_DECAY = 2'd1,
        REG_DAMP  = 2'd2,
        REG_WET   = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [PD_AW-1:0]   plen_m1;
        logic [DECAY_W-1:0] decay;
        logic [DAMP_W-1:0]  damp;
        logic [WET_W-1:0]   wet;
        logic               pd_clr;
    } t_cfg_bus;

    typedef struct packed {
        logic                re;
        logic [PD_AW-1:0]    raddr;
        logic                we;
        logic [PD_AW-1:0]    waddr;
        logic [SAMPLE_W-1:0] wdata;
    } t_pd_req;

    typedef struct packed {
        logic               re;
        logic [MAIN_AW-1:0] raddr;
        logic               we;
        logic [MAIN_AW-1:0] waddr;
        logic [STORE_W-1:0] wdata;
    } t_main_req;

endpackage
`default_nettype wire

// ----- design/car_ram.sv -----
`default_nettype none
module car_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ----- design/car_cfg.sv -----
`default_nettype none
module car_cfg (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [car_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [car_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output car_pkg::t_cfg_bus                   o_cfg
);

    localparam int PLW = car_pkg::PLEN_W;
    localparam int DCW = car_pkg::DECAY_W;
    localparam int DMW = car_pkg::DAMP_W;
    localparam int WTW = car_pkg::WET_W;
    localparam int PAW = car_pkg::PD_AW;

    logic [PLW-1:0] r_plen;
    logic [DCW-1:0] r_decay;
    logic [DMW-1:0] r_damp;
    logic [WTW-1:0] r_wet;
    logic [31:0]    plen_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_plen  <= PLW'(car_pkg::PLEN_RESET);
            r_decay <= DCW'(car_pkg::DECAY_RESET);
            r_damp  <= DMW'(car_pkg::DAMP_RESET);
            r_wet   <= WTW'(car_pkg::WET_RESET);
        end else if (i_cfg_we) begin
            unique case (car_pkg::t_reg_idx'(i_cfg_idx))
                car_pkg::REG_PLEN:  r_plen  <= i_cfg_data[PLW-1:0];
                car_pkg::REG_DECAY: r_decay <= i_cfg_data[DCW-1:0];
                car_pkg::REG_DAMP:  r_damp  <= i_cfg_data[DMW-1:0];
                car_pkg::REG_WET:   r_wet   <= i_cfg_data[WTW-1:0];
            endcase
        end
    end

    always_comb begin
        plen_eff = 32'(r_plen);
        if (plen_eff < 32'd1) begin
            plen_eff = 32'd1;
        end
        if (plen_eff > 32'(car_pkg::PREDELAY_MAX)) begin
            plen_eff = 32'(car_pkg::PREDELAY_MAX);
        end
        o_cfg.plen_m1 = PAW'(plen_eff - 32'd1);

        o_cfg.decay = r_decay;
        if (r_decay < DCW'(car_pkg::DECAY_LO)) begin
            o_cfg.decay = DCW'(car_pkg::DECAY_LO);
        end else if (r_decay > DCW'(car_pkg::DECAY_HI)) begin
            o_cfg.decay = DCW'(car_pkg::DECAY_HI);
        end

        o_cfg.damp = (r_damp > DMW'(car_pkg::DAMP_HI)) ? DMW'(car_pkg::DAMP_HI) : r_damp;
        o_cfg.wet  = (r_wet > WTW'(car_pkg::UNITY)) ? WTW'(car_pkg::UNITY) : r_wet;

        // predelay write empties the line
        o_cfg.pd_clr = i_cfg_we && (car_pkg::t_reg_idx'(i_cfg_idx) == car_pkg::REG_PLEN);
    end

endmodule
`default_nettype wire

// ----- design/car_seq.sv -----
`default_nettype none
module car_seq (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  car_pkg::t_cfg_bus                        i_cfg,
    input  wire logic signed [car_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    output logic signed      [car_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready,
    output car_pkg::t_pd_req                         o_pd_req,
    input  wire logic        [car_pkg::SAMPLE_W-1:0] i_pd_rdata,
    output car_pkg::t_main_req                       o_main_req,
    input  wire logic        [car_pkg::STORE_W-1:0]  i_main_rdata
);

    localparam int XW  = car_pkg::SAMPLE_W;
    localparam int SW  = car_pkg::STORE_W;
    localparam int DW  = SW + 1;
    localparam int WW  = 48;
    localparam int KDC = car_pkg::DECAY_W + 1;
    localparam int KDM = car_pkg::DAMP_W + 1;
    localparam int KWT = car_pkg::WET_W + 1;
    localparam int FPW = SW + KDC;
    localparam int BPW = DW + KDM;
    localparam int BSW = BPW + 1;
    localparam int MPW = DW + KWT;
    localparam int MSW = MPW + 1;
    localparam int MAW = car_pkg::MAIN_AW;
    localparam int PAW = car_pkg::PD_AW;
    localparam int P1W = car_pkg::C1_PW;
    localparam int P2W = car_pkg::C2_PW;
    localparam int P3W = car_pkg::D1_PW;
    localparam int P4W = car_pkg::D2_PW;
    localparam int RND = 16384;

    localparam logic signed [WW-1:0] S_HI = (WW'(1) <<< (SW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] S_LO = -(WW'(1) <<< (SW - 1));
    localparam logic signed [WW-1:0] X_HI = (WW'(1) <<< (XW - 1)) - WW'(1);
    localparam logic signed [WW-1:0] X_LO = -(WW'(1) <<< (XW - 1));

    localparam logic [P1W-1:0] C1_LAST = P1W'(car_pkg::C1_LEN - 1);
    localparam logic [P2W-1:0] C2_LAST = P2W'(car_pkg::C2_LEN - 1);
    localparam logic [P3W-1:0] D1_LAST = P3W'(car_pkg::D1_LEN - 1);
    localparam logic [P4W-1:0] D2_LAST = P4W'(car_pkg::D2_LEN - 1);

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_C1   = 8'b0000_0010,
        ST_C1O  = 8'b0000_0100,
        ST_C2   = 8'b0000_1000,
        ST_C2O  = 8'b0001_0000,
        ST_AP1  = 8'b0010_0000,
        ST_AP2  = 8'b0100_0000,
        ST_MIX  = 8'b1000_0000
    } t_state;

    function automatic logic signed [SW-1:0] sat_store(input logic signed [WW-1:0] v);
        if (v > S_HI) begin
            return SW'(S_HI);
        end
        if (v < S_LO) begin
            return SW'(S_LO);
        end
        return SW'(v);
    endfunction

    function automatic logic signed [XW-1:0] sat_sample(input logic signed [WW-1:0] v);
        if (v > X_HI) begin
            return XW'(X_HI);
        end
        if (v < X_LO) begin
            return XW'(X_LO);
        end
        return XW'(v);
    endfunction

    t_state r_state, n_state;

    logic [PAW-1:0] r_pd_ptr;
    logic [P1W-1:0] r_c1_ptr;
    logic [P2W-1:0] r_c2_ptr;
    logic [P3W-1:0] r_d1_ptr;
    logic [P4W-1:0] r_d2_ptr;
    logic           r_pd_wrap, r_c1_wrap, r_c2_wrap, r_d1_wrap, r_d2_wrap;
    logic           r_out_valid;

    logic signed [XW-1:0] r_x, r_pre, r_out;
    logic signed [SW-1:0] r_dly, r_fb, r_c1, r_sig;

    logic                  accept, out_free, main_ok;
    logic signed [SW-1:0]  mem_d;
    logic signed [XW-1:0]  pre_sel;
    logic signed [FPW-1:0] fb_prod, fb_rnd;
    logic signed [SW-1:0]  fb_val;
    logic signed [DW-1:0]  bl_diff;
    logic signed [BPW-1:0] bl_prod;
    logic signed [BSW-1:0] bl_sum;
    logic signed [SW-1:0]  c_out, sig_avg, ap_v, ap_out;
    logic signed [DW-1:0]  m_diff;
    logic signed [MPW-1:0] m_prod;
    logic signed [MSW-1:0] m_sum;
    logic signed [XW-1:0]  mix_val;
    logic [MAW-1:0]        c1_addr, c2_addr, d1_addr, d2_addr;

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    // entries not yet written since reset or clear read as zero
    assign main_ok = ((r_state == ST_C1) && r_c1_wrap) || ((r_state == ST_C2) && r_c2_wrap)
                  || ((r_state == ST_AP1) && r_d1_wrap) || ((r_state == ST_AP2) && r_d2_wrap);
    assign mem_d   = main_ok ? $signed(i_main_rdata) : '0;
    assign pre_sel = (r_state == ST_C1) ? (r_pd_wrap ? $signed(i_pd_rdata) : '0) : r_pre;

    // comb feedback
    assign fb_prod = mem_d * $signed({1'b0, i_cfg.decay});
    assign fb_rnd  = (fb_prod + RND) >>> 15;
    assign fb_val  = sat_store(WW'(fb_rnd) + WW'(pre_sel));

    // damped comb output: dly*(1-d) + fb*d == dly + (fb-dly)*d
    assign bl_diff = DW'(r_fb) - DW'(r_dly);
    assign bl_prod = bl_diff * $signed({1'b0, i_cfg.damp});
    assign bl_sum  = BSW'(bl_prod) + (BSW'(r_dly) <<< 15);
    assign c_out   = sat_store(WW'((bl_sum + RND) >>> 15));
    assign sig_avg = sat_store((WW'(r_c1) + WW'(c_out) + WW'(1)) >>> 1);

    // allpass, gain one half
    assign ap_v   = sat_store(WW'(r_sig) + ((-WW'(mem_d) + WW'(1)) >>> 1));
    assign ap_out = sat_store(WW'(mem_d) + ((WW'(ap_v) + WW'(1)) >>> 1));

    // wet/dry mix
    assign m_diff  = DW'(r_sig) - DW'(r_x);
    assign m_prod  = m_diff * $signed({1'b0, i_cfg.wet});
    assign m_sum   = MSW'(m_prod) + (MSW'(r_x) <<< 15);
    assign mix_val = sat_sample(WW'((m_sum + RND) >>> 15));

    assign c1_addr = MAW'(car_pkg::C1_BASE) + MAW'(r_c1_ptr);
    assign c2_addr = MAW'(car_pkg::C2_BASE) + MAW'(r_c2_ptr);
    assign d1_addr = MAW'(car_pkg::D1_BASE) + MAW'(r_d1_ptr);
    assign d2_addr = MAW'(car_pkg::D2_BASE) + MAW'(r_d2_ptr);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (i_in_valid) n_state = ST_C1;
            ST_C1:   n_state = ST_C1O;
            ST_C1O:  n_state = ST_C2;
            ST_C2:   n_state = ST_C2O;
            ST_C2O:  n_state = ST_AP1;
            ST_AP1:  n_state = ST_AP2;
            ST_AP2:  n_state = ST_MIX;
            ST_MIX:  if (out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_pd_req.re    = accept;
        o_pd_req.raddr = r_pd_ptr;
        o_pd_req.we    = (r_state == ST_C1);
        o_pd_req.waddr = r_pd_ptr;
        o_pd_req.wdata = r_x;

        o_main_req.re    = 1'b0;
        o_main_req.raddr = c1_addr;
        o_main_req.we    = 1'b0;
        o_main_req.waddr = c1_addr;
        o_main_req.wdata = fb_val;
        unique case (r_state)
            ST_IDLE: begin
                o_main_req.re = i_in_valid;
            end
            ST_C1: begin
                o_main_req.re    = 1'b1;
                o_main_req.raddr = c2_addr;
                o_main_req.we    = 1'b1;
            end
            ST_C2: begin
                o_main_req.re    = 1'b1;
                o_main_req.raddr = d1_addr;
                o_main_req.we    = 1'b1;
                o_main_req.waddr = c2_addr;
            end
            ST_AP1: begin
                o_main_req.re    = 1'b1;
                o_main_req.raddr = d2_addr;
                o_main_req.we    = 1'b1;
                o_main_req.waddr = d1_addr;
                o_main_req.wdata = ap_v;
            end
            ST_AP2: begin
                o_main_req.we    = 1'b1;
                o_main_req.waddr = d2_addr;
                o_main_req.wdata = ap_v;
            end
            default: begin
                o_main_req.re = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_pd_ptr    <= '0;
            r_c1_ptr    <= '0;
            r_c2_ptr    <= '0;
            r_d1_ptr    <= '0;
            r_d2_ptr    <= '0;
            r_pd_wrap   <= 1'b0;
            r_c1_wrap   <= 1'b0;
            r_c2_wrap   <= 1'b0;
            r_d1_wrap   <= 1'b0;
            r_d2_wrap   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg.pd_clr) begin
                r_pd_ptr  <= '0;
                r_pd_wrap <= 1'b0;
            end else if (r_state == ST_C1) begin
                if (r_pd_ptr == i_cfg.plen_m1) begin
                    r_pd_ptr  <= '0;
                    r_pd_wrap <= 1'b1;
                end else begin
                    r_pd_ptr <= r_pd_ptr + PAW'(1);
                end
            end

            if (r_state == ST_C1) begin
                if (r_c1_ptr == C1_LAST) begin
                    r_c1_ptr  <= '0;
                    r_c1_wrap <= 1'b1;
                end else begin
                    r_c1_ptr <= r_c1_ptr + P1W'(1);
                end
            end

            if (r_state == ST_C2) begin
                if (r_c2_ptr == C2_LAST) begin
                    r_c2_ptr  <= '0;
                    r_c2_wrap <= 1'b1;
                end else begin
                    r_c2_ptr <= r_c2_ptr + P2W'(1);
                end
            end

            if (r_state == ST_AP1) begin
                if (r_d1_ptr == D1_LAST) begin
                    r_d1_ptr  <= '0;
                    r_d1_wrap <= 1'b1;
                end else begin
                    r_d1_ptr <= r_d1_ptr + P3W'(1);
                end
            end

            if (r_state == ST_AP2) begin
                if (r_d2_ptr == D2_LAST) begin
                    r_d2_ptr  <= '0;
                    r_d2_wrap <= 1'b1;
                end else begin
                    r_d2_ptr <= r_d2_ptr + P4W'(1);
                end
            end

            if ((r_state == ST_MIX) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x <= i_sample_in;
        end
        if (r_state == ST_C1) begin
            r_pre <= pre_sel;
        end
        if ((r_state == ST_C1) || (r_state == ST_C2)) begin
            r_dly <= mem_d;
            r_fb  <= fb_val;
        end
        if (r_state == ST_C1O) begin
            r_c1 <= c_out;
        end
        if (r_state == ST_C2O) begin
            r_sig <= sig_avg;
        end
        if ((r_state == ST_AP1) || (r_state == ST_AP2)) begin
            r_sig <= ap_out;
        end
        if ((r_state == ST_MIX) && out_free) begin
            r_out <= mix_val;
        end
    end

    assign o_in_ready   = (r_state == ST_IDLE);
    assign o_out_valid  = r_out_valid;
    assign o_sample_out = r_out;

endmodule
`default_nettype wire

// ----- design/comb_allpass_reverb_core.sv -----
`default_nettype none
// Schroeder-style reverb: one 16-bit sample in, one 16-bit sample out per beat.
// Each accepted sample steps through the states C1, C1O, C2, C2O, AP1, AP2 and MIX
// into the output register, MIX waiting while the output is stalled. The input is
// ready again as the result lands: one sample is in flight at a time. The sequencer
// steps one read-modify-write per stage through the shared 24-bit delay memory (two
// combs, two allpass stages), with at most one multiply per state. The predelay line
// sits in its own 16-bit memory. Stores read as zero after reset, the predelay line also
// after a predelay_len write, with no clearing pass, so samples are taken right after
// reset. The user must write registers only while idle; the block does not enforce it.
module comb_allpass_reverb_core (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_cfg_we,
    input  wire logic        [car_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic        [car_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic signed [car_pkg::SAMPLE_W-1:0] i_sample_in,
    input  wire logic                                i_in_valid,
    output logic                                     o_in_ready,
    output logic signed      [car_pkg::SAMPLE_W-1:0] o_sample_out,
    output logic                                     o_out_valid,
    input  wire logic                                i_out_ready
);

    car_pkg::t_cfg_bus  cfg;
    car_pkg::t_pd_req   pd_req;
    car_pkg::t_main_req main_req;
    logic [car_pkg::SAMPLE_W-1:0] pd_rdata;
    logic [car_pkg::STORE_W-1:0]  main_rdata;

    car_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    car_ram #(
        .WIDTH (car_pkg::SAMPLE_W),
        .DEPTH (car_pkg::PREDELAY_MAX)
    ) u_pd_ram (
        .i_clk   (i_clk),
        .i_we    (pd_req.we),
        .i_waddr (pd_req.waddr),
        .i_wdata (pd_req.wdata),
        .i_re    (pd_req.re),
        .i_raddr (pd_req.raddr),
        .o_rdata (pd_rdata)
    );

    car_ram #(
        .WIDTH (car_pkg::STORE_W),
        .DEPTH (car_pkg::MAIN_DEPTH)
    ) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (main_req.we),
        .i_waddr (main_req.waddr),
        .i_wdata (main_req.wdata),
        .i_re    (main_req.re),
        .i_raddr (main_req.raddr),
        .o_rdata (main_rdata)
    );

    car_seq u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_sample_in  (i_sample_in),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .o_sample_out (o_sample_out),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pd_req     (pd_req),
        .i_pd_rdata   (pd_rdata),
        .o_main_req   (main_req),
        .i_main_rdata (main_rdata)
    );

endmodule
`default_nettype wire

// ----- design/car_chk.sv -----
`default_nettype none
module car_chk (
    input wire logic                          i_clk,
    input wire logic                          i_rst_n,
    input wire logic                          i_in_valid,
    input wire logic                          o_in_ready,
    input wire logic [car_pkg::SAMPLE_W-1:0]  o_sample_out,
    input wire logic                          o_out_valid,
    input wire logic                          i_out_ready
);

    // a sample is worked alone: no new beat until the sequence finishes
    ap_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready
            ##1 !o_in_ready ##1 !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("input taken again before the sample finished");

    // ready comes back only together with the finished result
    ap_result_on_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_in_ready) |-> o_out_valid)
        else $error("ready returned without a result");

    // a result appears only at the end of a sample's sequence
    ap_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> o_in_ready)
        else $error("result appeared mid-sequence");

    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_sample_out))
        else $error("stalled output beat changed");

endmodule

bind comb_allpass_reverb_core car_chk u_chk (.*);
`default_nettype wire

// ----- test/tb_comb_allpass_reverb_core.sv -----
`timescale 1ns / 1ps

module tb_comb_allpass_reverb_core;
    import car_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int N_PHASES   = 12;
    localparam int S24_MAX    = 8388607;
    localparam int S24_MIN    = -8388608;

    class reverb_checker;
        shortint                    pd_mem[PREDELAY_MAX];
        int                         c1_mem[C1_LEN];
        int                         c2_mem[C2_LEN];
        int                         d1_mem[D1_LEN];
        int                         d2_mem[D2_LEN];
        int unsigned                pd_ptr, c1_ptr, c2_ptr, d1_ptr, d2_ptr;
        int unsigned                plen_reg, decay_reg, damp_reg, wet_reg;
        logic signed [SAMPLE_W-1:0] mixed_q[$];
        int                         mismatches, checked, full_scale;

        function new();
            foreach (pd_mem[i]) pd_mem[i] = 0;
            foreach (c1_mem[i]) c1_mem[i] = 0;
            foreach (c2_mem[i]) c2_mem[i] = 0;
            foreach (d1_mem[i]) d1_mem[i] = 0;
            foreach (d2_mem[i]) d2_mem[i] = 0;
            pd_ptr = 0;
            c1_ptr = 0;
            c2_ptr = 0;
            d1_ptr = 0;
            d2_ptr = 0;
            plen_reg  = PLEN_RESET;
            decay_reg = DECAY_RESET;
            damp_reg  = DAMP_RESET;
            wet_reg   = WET_RESET;
            mismatches = 0;
            checked    = 0;
            full_scale = 0;
        endfunction

        // round half up: floor((x + 2^(s-1)) / 2^s)
        function longint rnd(longint x, int s);
            return (x + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint clip(longint x, longint lo, longint hi);
            if (x < lo) return lo;
            if (x > hi) return hi;
            return x;
        endfunction

        function int unsigned bump(int unsigned p, int unsigned len);
            return (p + 1 >= len) ? 0 : p + 1;
        endfunction

        function int comb_tap(inout int tap, input longint x, input longint decay,
                              input longint damp);
            longint d, fb;
            d  = tap;
            fb = clip(x + rnd(d * decay, 15), S24_MIN, S24_MAX);
            tap = int'(fb);
            return int'(clip(rnd(d * (UNITY - damp) + fb * damp, 15), S24_MIN, S24_MAX));
        endfunction

        function int allpass_tap(inout int tap, input longint x);
            longint b, v;
            b = tap;
            v = clip(x + rnd(-b, 1), S24_MIN, S24_MAX);
            tap = int'(v);
            return int'(clip(b + rnd(v, 1), S24_MIN, S24_MAX));
        endfunction

        function void write_reg(t_reg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_PLEN: begin
                    plen_reg = data[PLEN_W-1:0];
                    foreach (pd_mem[i]) pd_mem[i] = 0;
                    pd_ptr = 0;
                end
                REG_DECAY: decay_reg = data[DECAY_W-1:0];
                REG_DAMP:  damp_reg  = data[DAMP_W-1:0];
                REG_WET:   wet_reg   = data[WET_W-1:0];
            endcase
        endfunction

        function void take_sample(logic signed [SAMPLE_W-1:0] s);
            longint      x, decay, damp, wet, sig, mix;
            int unsigned plen, p;
            int          pre, c1, c2;
            x     = s;
            plen  = plen_reg;
            decay = decay_reg;
            damp  = damp_reg;
            wet   = wet_reg;
            if (plen < 1) plen = 1;
            if (plen > PREDELAY_MAX) plen = PREDELAY_MAX;
            if (decay < DECAY_LO) decay = DECAY_LO;
            if (decay > DECAY_HI) decay = DECAY_HI;
            if (damp > DAMP_HI) damp = DAMP_HI;
            if (wet > UNITY) wet = UNITY;

            p = (pd_ptr < plen) ? pd_ptr : 0;
            pre = pd_mem[p];
            pd_mem[p] = s;
            pd_ptr = bump(p, plen);

            c1 = comb_tap(c1_mem[c1_ptr], pre, decay, damp);
            c1_ptr = bump(c1_ptr, C1_LEN);
            c2 = comb_tap(c2_mem[c2_ptr], pre, decay, damp);
            c2_ptr = bump(c2_ptr, C2_LEN);
            sig = clip(rnd(longint'(c1) + c2, 1), S24_MIN, S24_MAX);

            sig = allpass_tap(d1_mem[d1_ptr], sig);
            d1_ptr = bump(d1_ptr, D1_LEN);
            sig = allpass_tap(d2_mem[d2_ptr], sig);
            d2_ptr = bump(d2_ptr, D2_LEN);

            mix = clip(rnd(x * (UNITY - wet) + sig * wet, 15), -32768, 32767);
            if (mix == 32767 || mix == -32768) full_scale++;
            mixed_q.push_back(16'(mix));
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= 40) $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_sample(logic signed [SAMPLE_W-1:0] got);
            logic signed [SAMPLE_W-1:0] want;
            checked++;
            if (mixed_q.size() == 0) begin
                report_mismatch($sformatf("sample_out %0d with no sample pending", got));
            end else begin
                want = mixed_q.pop_front();
                if (got !== want)
                    report_mismatch($sformatf("sample_out %0d, want %0d (beat %0d)",
                                              got, want, checked));
            end
        endtask

        function int pending();
            return mixed_q.size();
        endfunction
    endclass

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_idx = REG_PLEN;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;
    logic signed [SAMPLE_W-1:0] i_sample_in = '0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_ready;
    logic signed [SAMPLE_W-1:0] o_sample_out;
    logic                       o_out_valid;
    logic                       i_out_ready = 1'b0;

    reverb_checker sb = new();
    bit            in_gaps = 1'b1;
    bit            out_stalls = 1'b1;
    int            idle_cycles = 0;

    comb_allpass_reverb_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_sample_in (i_sample_in),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_sample_out(o_sample_out),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout: no beat for %0d cycles", IDLE_LIMIT);
            $display("tb_comb_allpass_reverb_core: FAIL");
            $finish;
        end
    end

    // output side
    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = out_stalls ? $urandom_range(0, 3) : 0;
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_sample(o_sample_out);
        end
    end

    task send_sample(input logic signed [SAMPLE_W-1:0] s);
        int gap;
        gap = in_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_sample_in <= s;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.take_sample(s);
    endtask

    task reg_beat(input t_reg_idx idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        sb.write_reg(idx, data);
    endtask

    task program_regs(input logic [CFG_DATA_W-1:0] plen, decay, damp, wet,
                      input bit with_plen);
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        @(posedge i_clk);
        if (with_plen) reg_beat(REG_PLEN, plen);
        reg_beat(REG_DECAY, decay);
        reg_beat(REG_DAMP, damp);
        reg_beat(REG_WET, wet);
        i_cfg_we <= 1'b0;
    endtask

    task play_phase(input int n, input bit loud);
        logic signed [SAMPLE_W-1:0] s, level;
        int                         run_left;
        level    = 16'sh7FFF;
        run_left = $urandom_range(40, 300);
        for (int k = 0; k < n; k++) begin
            if (loud) begin
                if (run_left == 0) begin
                    run_left = $urandom_range(40, 300);
                    level    = ~level;
                end
                run_left--;
                s = level;
            end else begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: s = 16'($urandom);
                    5, 6:          s = 16'(int'($urandom_range(0, 512)) - 256);
                    7:             s = 16'sh7FFF;
                    8:             s = 16'sh8000;
                    default:       s = '0;
                endcase
            end
            send_sample(s);
        end
    endtask

    logic [CFG_DATA_W-1:0] plen_tab[6]  = '{16'd1, 16'h0000, 16'd5, 16'd4096, 16'hFFFF, 16'd3};
    logic [CFG_DATA_W-1:0] decay_tab[6] = '{16'hFFFF, 16'h0000, 16'd31130, 16'd1638,
                                            16'd20000, 16'd1637};
    logic [CFG_DATA_W-1:0] damp_tab[6]  = '{16'd0, 16'hFFFF, 16'd29491, 16'd0,
                                            16'd29492, 16'd12345};
    logic [CFG_DATA_W-1:0] wet_tab[6]   = '{16'd32768, 16'hFFFF, 16'd32768, 16'd0,
                                            16'd32769, 16'd26000};
    logic signed [SAMPLE_W-1:0] corner_tab[16] = '{
        16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF, 16'sh5555, 16'shAAAA, 16'sh00FF,
        16'shFF00, 16'sh4000, 16'shC000, 16'sh7FFE, 16'sh8001, 16'sh0002, 16'sh0000, 16'sh7FFF
    };

    initial begin
        logic [CFG_DATA_W-1:0] plen, decay, damp, wet;
        bit                    with_plen, loud;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (corner_tab[k]) send_sample(corner_tab[k]);

        for (int p = 0; p < N_PHASES; p++) begin
            if (p < 6) begin
                plen      = plen_tab[p];
                decay     = decay_tab[p];
                damp      = damp_tab[p];
                wet       = wet_tab[p];
                with_plen = 1'b1;
                loud      = 1'b0;
            end else begin
                loud      = (p >= N_PHASES - 3) || ($urandom_range(0, 3) == 0);
                with_plen = 1'($urandom_range(0, 1));
                plen      = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(1, 48));
                decay     = loud ? 16'($urandom_range(29000, 32767)) : 16'($urandom);
                damp      = 16'($urandom);
                wet       = loud ? 16'($urandom_range(28000, 40000)) : 16'($urandom);
            end
            in_gaps    = ($urandom_range(0, 3) != 0);
            out_stalls = ($urandom_range(0, 3) != 0);
            program_regs(plen, decay, damp, wet, with_plen);
            play_phase($urandom_range(110, 150), loud);
        end

        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d output samples across reset defaults and %0d register settings;",
                 sb.checked, N_PHASES);
        $display("%0d expected outputs sat at full scale, %0d mismatches.",
                 sb.full_scale, sb.mismatches);
        if (sb.mismatches == 0 && sb.pending() == 0) begin
            $display("tb_comb_allpass_reverb_core: PASS");
        end else begin
            $display("tb_comb_allpass_reverb_core: FAIL");
        end
        $finish;
    end

endmodule
